// ===== rtl/b2d_pkg.sv =====
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared constants, helpers and types for the binary to decimal ASCII core.
// ----------------------------------------------------------------------------
`default_nettype none

package b2d_pkg;

  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned QueueDepth       = 2;

  localparam logic [5:0] AsciiZero   = 6'h30;
  localparam logic [3:0] DabbleLimit = 4'd5;
  localparam logic [3:0] DabbleAdd   = 4'd3;

  // Decimal digits needed for the largest value of a w-bit word:
  // floor(w * log10(2)) + 1, with log10(2) close to 1233 / 4096.
  function automatic int unsigned num_digits(int unsigned w);
    return ((w * 1233) >> 12) + 1;
  endfunction

  typedef enum logic [1:0] {
    FrontIdle,
    FrontConv,
    FrontPush
  } front_state_e;

endpackage

`default_nettype wire

// ===== rtl/b2d_front.sv =====
// ----------------------------------------------------------------------------
// b2d_front
// Accepts a binary value, runs the shift-and-add-3 loop one bit per cycle,
// finds the top nonzero digit and writes the result into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_front #(
  parameter int unsigned DATA_WIDTH = b2d_pkg::DataWidthDefault,
  parameter int unsigned NUM_DIGITS = b2d_pkg::num_digits(DATA_WIDTH),
  parameter int unsigned IDX_W      = $clog2(NUM_DIGITS)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic [DATA_WIDTH-1:0]         value_i,
  output logic                               q_wr_o,
  output logic [IDX_W+4*NUM_DIGITS-1:0]      q_data_o,
  input  wire logic                          q_full_i
);
  import b2d_pkg::*;

  localparam int unsigned BcdW = 4 * NUM_DIGITS;
  localparam int unsigned CntW = $clog2(DATA_WIDTH);

  front_state_e          state_q, state_d;
  logic [DATA_WIDTH-1:0] shift_q, shift_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [BcdW-1:0]       bcd_adj;
  logic [IDX_W-1:0]      top_idx;

  // Correct every digit of 5 or more before the shift.
  always_comb begin
    logic [3:0] nib;
    nib     = '0;
    bcd_adj = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      nib = bcd_q[4*i +: 4];
      bcd_adj[4*i +: 4] = (nib >= DabbleLimit) ? nib + DabbleAdd : nib;
    end
  end

  // Highest nonzero digit; zero keeps index 0 so a single '0' goes out.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) top_idx = IDX_W'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrontIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    bcd_q   <= bcd_d;
  end

  always_comb begin
    state_d = state_q;
    shift_d = shift_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    q_wr_o  = 1'b0;
    case (state_q)
      FrontIdle: begin
        if (push_i) begin
          shift_d = value_i;
          bcd_d   = '0;
          cnt_d   = CntW'(DATA_WIDTH - 1);
          state_d = FrontConv;
        end
      end
      FrontConv: begin
        bcd_d   = {bcd_adj[BcdW-2:0], shift_q[DATA_WIDTH-1]};
        shift_d = {shift_q[DATA_WIDTH-2:0], 1'b0};
        if (cnt_q == '0) begin
          state_d = FrontPush;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      FrontPush: begin
        // hold the digits until the queue has room
        if (!q_full_i) begin
          q_wr_o  = 1'b1;
          state_d = FrontIdle;
        end
      end
      default: state_d = FrontIdle;
    endcase
  end

  assign full_o   = (state_q != FrontIdle);
  assign q_data_o = {top_idx, bcd_q};

endmodule

`default_nettype wire

// ===== rtl/b2d_queue.sv =====
// ----------------------------------------------------------------------------
// b2d_queue
// Short first-in first-out buffer between the converter and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = b2d_pkg::QueueDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      rd_data_o
);
  import b2d_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_rd) rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

`default_nettype wire

// ===== rtl/b2d_emit.sv =====
// ----------------------------------------------------------------------------
// b2d_emit
// Takes one converted number from the queue and presents its digits as
// ASCII characters, most significant first, one per pop.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_emit #(
  parameter int unsigned NUM_DIGITS = b2d_pkg::num_digits(b2d_pkg::DataWidthDefault),
  parameter int unsigned IDX_W      = $clog2(NUM_DIGITS)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  wire logic [IDX_W+4*NUM_DIGITS-1:0] q_data_i,
  output logic                               q_rd_o,
  output logic                               empty_o,
  input  wire logic                          pop_i,
  output logic [5:0]                         digit_char_o,
  output logic                               last_o
);
  import b2d_pkg::*;

  localparam int unsigned BcdW = 4 * NUM_DIGITS;

  logic                busy_q;
  logic [IDX_W-1:0]    idx_q;
  logic [BcdW-1:0]     bcd_q;
  logic [3:0]          cur_digit;
  logic                take;

  assign cur_digit    = bcd_q[{idx_q, 2'b00} +: 4];
  assign last_o       = (idx_q == '0);
  assign empty_o      = !busy_q;
  assign digit_char_o = AsciiZero + {2'b00, cur_digit};
  assign take         = pop_i && busy_q;

  // load the next number once the final digit of this one is taken
  assign q_rd_o = q_valid_i && (!busy_q || (take && last_o));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (q_rd_o) begin
      busy_q <= 1'b1;
      idx_q  <= q_data_i[BcdW +: IDX_W];
    end else if (take) begin
      if (last_o) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) bcd_q <= q_data_i[BcdW-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/binary_to_decimal_ascii_core.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Unsigned binary to decimal ASCII text, most significant digit first.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | push_i / full_o    | value_i [DATA_WIDTH-1:0]
//  result   | pop_i / empty_o    | digit_char_o [5:0], last_o (final digit)
//
//  In the converter an item is accepted, goes through the shift-and-add-3
//  loop over every bit and is then written to the queue. That loop sets the
//  rate, as the converter takes no new value until it has written the last
//  one, while the emitter drains digits at one per cycle in parallel
//  whenever pop_i is high. Results of up to two numbers wait in the queue,
//  so the converter stalls only when both slots and the emitter are
//  occupied. Reset idles the converter and empties the queue and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_decimal_ascii_core #(
  parameter int unsigned DATA_WIDTH = b2d_pkg::DataWidthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire logic [DATA_WIDTH-1:0] value_i,
  output logic                       empty_o,
  input  wire logic                  pop_i,
  output logic [5:0]                 digit_char_o,
  output logic                       last_o
);
  import b2d_pkg::*;

  localparam int unsigned NumDigits = num_digits(DATA_WIDTH);
  localparam int unsigned IdxW      = $clog2(NumDigits);
  localparam int unsigned EntryW    = IdxW + 4 * NumDigits;

  logic              q_wr, q_full, q_valid, q_rd;
  logic [EntryW-1:0] q_wr_data, q_rd_data;

  b2d_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .NUM_DIGITS (NumDigits),
    .IDX_W      (IdxW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push_i),
    .full_o   (full_o),
    .value_i  (value_i),
    .q_wr_o   (q_wr),
    .q_data_o (q_wr_data),
    .q_full_i (q_full)
  );

  b2d_queue #(
    .WIDTH (EntryW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_data),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .valid_o   (q_valid),
    .rd_data_o (q_rd_data)
  );

  b2d_emit #(
    .NUM_DIGITS (NumDigits),
    .IDX_W      (IdxW)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_rd_data),
    .q_rd_o       (q_rd),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/b2d_checker.sv =====
// ----------------------------------------------------------------------------
// b2d_checker
// Port-level checks for the binary to decimal ASCII core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module b2d_checker #(
  parameter int unsigned DATA_WIDTH = b2d_pkg::DataWidthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic                  full_o,
  input  wire logic [DATA_WIDTH-1:0] value_i,
  input  wire logic                  empty_o,
  input  wire logic                  pop_i,
  input  wire logic [5:0]            digit_char_o,
  input  wire logic                  last_o
);
  import b2d_pkg::*;

  logic first_q;

  // track whether the shown item opens a new number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (pop_i && !empty_o) begin
      first_q <= last_o;
    end
  end

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(digit_char_o) && $stable(last_o)))
    else $error("result changed while stalled");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (digit_char_o >= AsciiZero && digit_char_o <= AsciiZero + 6'd9))
    else $error("result is not a decimal digit");

  a_no_leading_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && first_q && digit_char_o == AsciiZero) |-> last_o)
    else $error("leading zero emitted");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o) |=> full_o)
    else $error("converter took no hold of accepted item");

  a_value_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o) |-> !$isunknown(value_i))
    else $error("accepted value has unknown bits");

endmodule

bind binary_to_decimal_ascii_core b2d_checker #(.DATA_WIDTH(DATA_WIDTH)) u_b2d_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for binary_to_decimal_ascii_core. Numbers go in through
// the push/full side and each one is expanded here into its decimal ASCII
// digits. Digits popped from the core are compared against that list in
// order. Sender and receiver idle at varying rates, with one long receiver
// hold-off that backs the core up.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned Width       = b2d_pkg::DataWidthDefault;
  localparam int unsigned Radix       = 10;
  localparam int unsigned RandomItems = 450;
  localparam int unsigned PhaseOneEnd = 160;
  localparam int unsigned PhaseTwoEnd = 320;
  localparam int unsigned HoldAt      = 360;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned IdleLimit   = 4000;

  typedef struct packed {
    logic [5:0] code;
    logic       last;
  } digit_t;

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             push_i  = 1'b0;
  logic [Width-1:0] value_i = '0;
  logic             pop_i   = 1'b0;
  logic             full_o;
  logic             empty_o;
  logic [5:0]       digit_char_o;
  logic             last_o;

  logic [Width-1:0] number_q [$];
  digit_t           digit_q  [$];
  int unsigned      n_items;
  int unsigned      n_sent = 0;
  int unsigned      err_count = 0;
  int unsigned      hold_left = 0;
  logic             hold_done = 1'b0;
  int unsigned      quiet_cycles = 0;
  logic             push_take;
  logic             pop_take;

  int unsigned pow10_tbl [10] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                                  10000000, 100000000, 1000000000};

  binary_to_decimal_ascii_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .value_i      (value_i),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Expand one number into its digit characters, most significant first.
  task automatic queue_decimal_digits(input logic [Width-1:0] num);
    logic [Width-1:0] rest;
    logic [3:0]       digs [$];
    digit_t           d;
    rest = num;
    do begin
      digs.push_front(4'(rest % Radix));
      rest = rest / Radix;
    end while (rest != 0);
    foreach (digs[k]) begin
      d.code = b2d_pkg::AsciiZero + 6'(digs[k]);
      d.last = (k == digs.size() - 1);
      digit_q.push_back(d);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic int unsigned sender_idle_pct(input int unsigned sent);
    if (sent < PhaseOneEnd) return 32;
    if (sent < PhaseTwoEnd) return 78;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct(input int unsigned sent);
    if (sent < PhaseOneEnd) return 78;
    if (sent < PhaseTwoEnd) return 32;
    return 0;
  endfunction

  // Driver: hold an item until it is taken, then load the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_i  <= 1'b0;
      value_i <= '0;
    end else begin
      push_take = push_i && !full_o;
      if (push_take) begin
        queue_decimal_digits(value_i);
        n_sent <= n_sent + 1;
      end
      if (!push_i || push_take) begin
        if (number_q.size() != 0 &&
            $urandom_range(0, 99) >= sender_idle_pct(n_sent)) begin
          push_i  <= 1'b1;
          value_i <= number_q.pop_front();
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each popped digit, then decide whether to pop next cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      if (pop_i && !empty_o) begin
        if (digit_q.size() == 0) begin
          report_mismatch("digit with nothing pending", digit_char_o, -1);
        end else begin
          if (digit_char_o !== digit_q[0].code)
            report_mismatch("digit_char", digit_char_o, digit_q[0].code);
          if (last_o !== digit_q[0].last)
            report_mismatch("last", last_o, digit_q[0].last);
          void'(digit_q.pop_front());
        end
      end
      // Hold off once for a long stretch so the core fills and stalls its input.
      if (!hold_done && n_sent >= HoldAt) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        pop_i     <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop_i     <= 1'b0;
      end else begin
        pop_i <= ($urandom_range(0, 99) >= receiver_idle_pct(n_sent));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      pop_take = pop_i && !empty_o;
      if ((push_i && !full_o) || pop_take) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IdleLimit) begin
        $display("TIMEOUT: no transfer for %0d cycles", IdleLimit);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned      sel;
    int unsigned      nd;
    logic [Width-1:0] hi;
    logic [Width-1:0] val;

    // Directed: zero, single digits, decade edges, all ones, bit patterns.
    number_q = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999999999,
                 32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'd123456789,
                 32'd4000000000, 32'd1000000001, 32'd0};

    for (int i = 0; i < RandomItems; i++) begin
      sel = $urandom_range(0, 9);
      nd  = $urandom_range(0, 9);
      hi  = (nd == 9) ? 32'hFFFF_FFFF : pow10_tbl[nd + 1] - 1;
      if (sel < 4)
        val = $urandom();
      else if (sel < 8)
        val = $urandom_range(hi, pow10_tbl[nd]);
      else
        val = pow10_tbl[nd] - 1 + $urandom_range(0, 2);  // straddle a decade edge
      number_q.push_back(val);
    end
    n_items = number_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_sent == n_items && digit_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
